>>> rtl/cpe_pkg.sv
// Shared types and constants of the absorbing-potential evaluator.
// Used by cpe_ctrl, cpe_dp and the top level; depends on nothing.
package cpe_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int USH        = 2 * FRAC_BITS - 16;
    localparam int DIV_W      = 65;
    localparam int DVD_W      = 96;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [63:0] DMIN0 = (2 * FRAC_BITS <= 43) ?
                                    (64'd1000000 << (2 * FRAC_BITS)) : '1;
    localparam logic [62:0] OUT_MAX = '1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CAP_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_X   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_Y   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_Z   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT    = 3'd5;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic [1:0] MODE_BOX = 2'd0;
    localparam logic [1:0] MODE_VOR = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [2:0] MUL_X   = 3'd0;
    localparam logic [2:0] MUL_Y   = 3'd1;
    localparam logic [2:0] MUL_Z   = 3'd2;
    localparam logic [2:0] MUL_WHI = 3'd3;
    localparam logic [2:0] MUL_WLO = 3'd4;
    localparam logic [2:0] MUL_E   = 3'd5;

    localparam logic [1:0] DIV_ONE  = 2'd0;
    localparam logic [1:0] DIV_V    = 2'd1;
    localparam logic [1:0] DIV_MEAN = 2'd2;

    localparam logic [2:0] RES_ZERO  = 3'd0;
    localparam logic [2:0] RES_NODEN = 3'd1;
    localparam logic [2:0] RES_SAT   = 3'd2;
    localparam logic [2:0] RES_D2    = 3'd3;
    localparam logic [2:0] RES_PROD  = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       wr_atom;
        logic       mem_rd;
        logic       calc_box;
        logic       calc_dist;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       d2_clr;
        logic       d2_acc;
        logic       dmin_upd;
        logic       vor_init;
        logic       calc_u;
        logic       div_start;
        logic [1:0] div_src;
        logic       w_load;
        logic       p_load;
        logic       p_add;
        logic       num_add;
        logic       sq_start;
        logic       res_set;
        logic [2:0] res_sel;
    } t_cmd;

    typedef struct packed {
        logic       op;
        logic [1:0] mode;
        logic       areal;
        logic       den_zero;
        logic       q_over;
        logic       root_le_cut;
        logic       dv_busy;
        logic       sq_done;
    } t_sts;

endpackage

>>> rtl/cap_potential_evaluator.sv
// Absorbing-potential evaluator: load requests fill the atom table, evaluate requests
// return one potential. One request at a time. A voronoi evaluation runs the bit-serial
// divider twice per real atom and once per point, then the root loop.
// Synchronous active-low reset clears the config registers, the real flags and control;
// the coordinate tables are not cleared.
module cap_potential_evaluator import cpe_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // atom_slot[5:0], pos_x[37:6], pos_y[69:38], pos_z[101:70], atom_real[102], zero pad
    input  logic [103:0]          s_axis_tdata,
    // operation[0]
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // potential[62:0], status[64:63], zero pad
    output logic [71:0]           m_axis_tdata
);

    localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [AW-1:0]    w_rd_addr;
    logic [CNT_W-1:0] w_n_eff;
    logic [62:0]      w_pot;
    logic [1:0]       w_status;
    logic             w_emit, w_out_free;
    logic             r_out_valid;
    logic [71:0]      r_out_data;

    // The output register parts the result side from the sequencer: hold a finished
    // result here while the sequencer takes the next request.
    assign w_out_free = !r_out_valid || m_axis_tready;

    cpe_ctrl #(.MAX_ATOMS(MAX_ATOMS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .i_sts      (w_sts),
        .i_n_eff    (w_n_eff),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    cpe_dp #(.MAX_ATOMS(MAX_ATOMS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_atom_slot (s_axis_tdata[5:0]),
        .i_pos_x     (s_axis_tdata[37:6]),
        .i_pos_y     (s_axis_tdata[69:38]),
        .i_pos_z     (s_axis_tdata[101:70]),
        .i_atom_real (s_axis_tdata[102]),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .o_sts       (w_sts),
        .o_n_eff     (w_n_eff),
        .o_potential (w_pot),
        .o_status    (w_status)
    );

    // Advance the output register on emit; drop valid once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) r_out_data <= {7'b0, w_status, w_pot};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/cpe_dp.sv
// Datapath: config registers, atom tables, multiplier, divider, square root.
// Depends on cpe_pkg; driven by commands from cpe_ctrl.
module cpe_dp import cpe_pkg::*; #(
    parameter int MAX_ATOMS = 64,
    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int CNT_W = $clog2(MAX_ATOMS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_op,
    input  logic [5:0]            i_atom_slot,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic                  i_atom_real,
    input  t_cmd                  i_cmd,
    input  logic [AW-1:0]         i_rd_addr,
    output t_sts                  o_sts,
    output logic [CNT_W-1:0]      o_n_eff,
    output logic [62:0]           o_potential,
    output logic [1:0]            o_status
);

    localparam int DEN_W = 34 + $clog2(MAX_ATOMS + 1);

    function automatic logic [31:0] abs33(input logic [32:0] d);
        return d[32] ? 32'(-d) : 32'(d);
    endfunction

    // config
    logic [1:0]  r_mode;
    logic [30:0] r_half_x, r_half_y, r_half_z, r_cut;
    logic [6:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_half_x <= '0;
            r_half_y <= '0;
            r_half_z <= '0;
            r_cut    <= '0;
            r_count  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_CAP_MODE: r_mode   <= i_cfg_wdata[1:0];
                CFG_HALF_X:   r_half_x <= i_cfg_wdata;
                CFG_HALF_Y:   r_half_y <= i_cfg_wdata;
                CFG_HALF_Z:   r_half_z <= i_cfg_wdata;
                CFG_CUTOFF:   r_cut    <= i_cfg_wdata;
                CFG_COUNT:    r_count  <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_count) >= 32'(MAX_ATOMS)) o_n_eff = CNT_W'(MAX_ATOMS);
        else                                 o_n_eff = CNT_W'(r_count);
    end

    // captured request
    logic              r_op, r_real_in;
    logic [5:0]        r_slot;
    logic signed [31:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_slot    <= i_atom_slot;
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_pz      <= i_pos_z;
            r_real_in <= i_atom_real;
        end
    end

    // atom tables
    logic [31:0] r_mem_x [MAX_ATOMS];
    logic [31:0] r_mem_y [MAX_ATOMS];
    logic [31:0] r_mem_z [MAX_ATOMS];
    logic        r_real  [MAX_ATOMS];
    logic [31:0] r_ax, r_ay, r_az;
    logic        r_areal;
    logic        w_slot_ok;
    logic [AW-1:0] w_wr_addr;

    assign w_slot_ok = (32'(r_slot) < 32'(MAX_ATOMS));
    assign w_wr_addr = AW'(r_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_atom && w_slot_ok) begin
            r_mem_x[w_wr_addr] <= r_px;
            r_mem_y[w_wr_addr] <= r_py;
            r_mem_z[w_wr_addr] <= r_pz;
        end
        if (i_cmd.mem_rd) begin
            r_ax <= r_mem_x[i_rd_addr];
            r_ay <= r_mem_y[i_rd_addr];
            r_az <= r_mem_z[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ATOMS; k++) r_real[k] <= 1'b0;
            r_areal <= 1'b0;
        end else begin
            if (i_cmd.wr_atom && w_slot_ok) r_real[w_wr_addr] <= r_real_in;
            if (i_cmd.mem_rd)               r_areal <= r_real[i_rd_addr];
        end
    end

    // per-axis magnitudes
    logic [31:0] r_ex, r_ey, r_ez;
    logic [31:0] w_mx, w_my, w_mz;

    assign w_mx = abs33({r_px[31], r_px});
    assign w_my = abs33({r_py[31], r_py});
    assign w_mz = abs33({r_pz[31], r_pz});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_box) begin
            r_ex <= (w_mx > {1'b0, r_half_x}) ? w_mx - {1'b0, r_half_x} : '0;
            r_ey <= (w_my > {1'b0, r_half_y}) ? w_my - {1'b0, r_half_y} : '0;
            r_ez <= (w_mz > {1'b0, r_half_z}) ? w_mz - {1'b0, r_half_z} : '0;
        end else if (i_cmd.calc_dist) begin
            r_ex <= abs33({r_px[31], r_px} - {r_ax[31], r_ax});
            r_ey <= abs33({r_py[31], r_py} - {r_ay[31], r_ay});
            r_ez <= abs33({r_pz[31], r_pz} - {r_az[31], r_az});
        end
    end

    // shared multiplier
    logic [63:0] r_prod, r_d2, r_dmin, r_num, r_p;
    logic [32:0] r_w;
    logic [63:0] r_sq_res;
    logic [32:0] w_ma, w_mb, w_e;

    assign w_e = r_sq_res[32:0] - {2'b0, r_cut};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_X:   begin w_ma = {1'b0, r_ex};         w_mb = {1'b0, r_ex}; end
            MUL_Y:   begin w_ma = {1'b0, r_ey};         w_mb = {1'b0, r_ey}; end
            MUL_Z:   begin w_ma = {1'b0, r_ez};         w_mb = {1'b0, r_ez}; end
            MUL_WHI: begin w_ma = {1'b0, r_d2[63:32]};  w_mb = r_w;          end
            MUL_WLO: begin w_ma = {1'b0, r_d2[31:0]};   w_mb = r_w;          end
            default: begin w_ma = w_e;                  w_mb = w_e;          end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= 64'(w_ma * w_mb);
    end

    // accumulators
    logic [64:0] w_d2_sum, w_p_sum, w_num_sum;
    logic [63:0] w_t;
    logic [DEN_W-1:0] r_den;
    logic        r_sat;
    logic [DIV_W-1:0] r_u;

    assign w_d2_sum  = {1'b0, r_d2} + {1'b0, r_prod};
    assign w_p_sum   = {1'b0, r_p} + {33'b0, r_prod[63:32]};
    assign w_num_sum = {1'b0, r_num} + {1'b0, r_p};
    assign w_t       = r_d2 - r_dmin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.d2_clr)      r_d2 <= '0;
        else if (i_cmd.d2_acc) r_d2 <= w_d2_sum[64] ? '1 : w_d2_sum[63:0];
        if (i_cmd.vor_init) begin
            r_dmin <= DMIN0;
            r_num  <= '0;
            r_den  <= '0;
            r_sat  <= 1'b0;
        end else begin
            if (i_cmd.dmin_upd && (r_d2 < r_dmin)) r_dmin <= r_d2;
            if (i_cmd.p_add) begin
                r_p <= w_p_sum[64] ? '1 : w_p_sum[63:0];
                if (w_p_sum[64]) r_sat <= 1'b1;
            end
            if (i_cmd.num_add) begin
                r_num <= w_num_sum[64] ? '1 : w_num_sum[63:0];
                if (w_num_sum[64]) r_sat <= 1'b1;
                r_den <= r_den + DEN_W'(r_w);
            end
        end
        if (i_cmd.p_load) r_p <= r_prod;
        if (i_cmd.calc_u) r_u <= DIV_W'(w_t >> USH) + DIV_W'(65536);
    end

    // restoring divider, one quotient bit a cycle
    logic [DIV_W-1:0] r_rem, r_div;
    logic [DVD_W-1:0] r_dvd, r_quo;
    logic [6:0]       r_dv_cnt;
    logic [DIV_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= '0;
            case (i_cmd.div_src)
                DIV_ONE: begin
                    r_dvd    <= {1'b1, {(DVD_W-1){1'b0}}};
                    r_div    <= r_u;
                    r_dv_cnt <= 7'd65;
                end
                DIV_V: begin
                    r_dvd    <= {r_quo[48:0], 47'b0};
                    r_div    <= r_u;
                    r_dv_cnt <= 7'd49;
                end
                default: begin
                    r_dvd    <= {r_num, 32'b0};
                    r_div    <= DIV_W'(r_den);
                    r_dv_cnt <= 7'd96;
                end
            endcase
        end else if (r_dv_cnt != '0) begin
            r_rem    <= w_ge ? DIV_W'(w_sh - {1'b0, r_div}) : DIV_W'(w_sh);
            r_quo    <= {r_quo[DVD_W-2:0], w_ge};
            r_dvd    <= {r_dvd[DVD_W-2:0], 1'b0};
            r_dv_cnt <= r_dv_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_load) r_w <= r_quo[32:0];
    end

    // bitwise integer square root, one result bit a cycle
    logic [63:0] r_sq_v, r_sq_bit, w_sq_try;

    assign w_sq_try = r_sq_res + r_sq_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_sq_v   <= r_quo[63:0];
            r_sq_res <= '0;
            r_sq_bit <= 64'd1 << 62;
        end else if (r_sq_bit != '0) begin
            if (r_sq_v >= w_sq_try) begin
                r_sq_v   <= r_sq_v - w_sq_try;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_sel)
                RES_NODEN: begin o_potential <= '0;      o_status <= ST_NODEN; end
                RES_SAT:   begin o_potential <= OUT_MAX; o_status <= ST_SAT;   end
                RES_D2: begin
                    o_potential <= r_d2[63] ? OUT_MAX : r_d2[62:0];
                    o_status    <= r_d2[63] ? ST_SAT : ST_OK;
                end
                RES_PROD: begin
                    o_potential <= r_prod[63] ? OUT_MAX : r_prod[62:0];
                    o_status    <= r_prod[63] ? ST_SAT : ST_OK;
                end
                default:   begin o_potential <= '0;      o_status <= ST_OK;    end
            endcase
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.mode        = r_mode;
    assign o_sts.areal       = r_areal;
    assign o_sts.den_zero    = (r_den == '0);
    assign o_sts.q_over      = r_sat || (r_quo[95:64] != '0);
    assign o_sts.root_le_cut = (r_sq_res <= {33'b0, r_cut});
    assign o_sts.dv_busy     = (r_dv_cnt != '0);
    assign o_sts.sq_done     = (r_sq_bit == '0);

endmodule

>>> rtl/cpe_ctrl.sv
// Sequencer: walks the atom table twice per voronoi evaluation and steps the datapath.
// Depends on cpe_pkg; drives cpe_dp through t_cmd and reads t_sts.
module cpe_ctrl import cpe_pkg::*; #(
    parameter int MAX_ATOMS = 64,
    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int CNT_W = $clog2(MAX_ATOMS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_free,
    output logic             o_emit,
    input  t_sts             i_sts,
    input  logic [CNT_W-1:0] i_n_eff,
    output t_cmd             o_cmd,
    output logic [AW-1:0]    o_rd_addr
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_BEXC = 5'd2,  S_BMX  = 5'd3;
    localparam logic [4:0] S_BMY  = 5'd4,  S_BMZ  = 5'd5,  S_BACC = 5'd6,  S_BRES = 5'd7;
    localparam logic [4:0] S_VINIT = 5'd8, S_RD   = 5'd9,  S_DIFF = 5'd10, S_MX   = 5'd11;
    localparam logic [4:0] S_MY   = 5'd12, S_MZ   = 5'd13, S_ACC  = 5'd14, S_MIN  = 5'd15;
    localparam logic [4:0] S_U    = 5'd16, S_DV1  = 5'd17, S_DV1W = 5'd18, S_DV2W = 5'd19;
    localparam logic [4:0] S_WLD  = 5'd20, S_MHI  = 5'd21, S_MLO  = 5'd22, S_PADD = 5'd23;
    localparam logic [4:0] S_NUM  = 5'd24, S_FCHK = 5'd25, S_FDW  = 5'd26, S_FQ   = 5'd27;
    localparam logic [4:0] S_SQW  = 5'd28, S_FCMP = 5'd29, S_FE   = 5'd30, S_EMIT = 5'd31;

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_pass  <= n_pass;
        end
    end

    assign o_rd_addr = r_j[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.op == OP_LOAD) begin
                    o_cmd.wr_atom = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.mode == MODE_BOX) begin
                    n_state = S_BEXC;
                end else if (i_sts.mode == MODE_VOR) begin
                    n_state = S_VINIT;
                end else begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_ZERO;
                    n_state       = S_EMIT;
                end
            end
            S_BEXC: begin
                o_cmd.calc_box = 1'b1;
                n_state        = S_BMX;
            end
            S_BMX, S_MX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_X;
                o_cmd.d2_clr  = 1'b1;
                n_state       = (r_state == S_BMX) ? S_BMY : S_MY;
            end
            S_BMY, S_MY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Y;
                o_cmd.d2_acc  = 1'b1;
                n_state       = (r_state == S_BMY) ? S_BMZ : S_MZ;
            end
            S_BMZ, S_MZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Z;
                o_cmd.d2_acc  = 1'b1;
                n_state       = (r_state == S_BMZ) ? S_BACC : S_ACC;
            end
            S_BACC: begin
                o_cmd.d2_acc = 1'b1;
                n_state      = S_BRES;
            end
            S_BRES: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = RES_D2;
                n_state       = S_EMIT;
            end
            S_VINIT: begin
                o_cmd.vor_init = 1'b1;
                n_j            = '0;
                n_pass         = 1'b0;
                n_state        = S_RD;
            end
            S_RD: begin
                if (r_j == i_n_eff) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_j    = '0;
                    end else begin
                        n_state = S_FCHK;
                    end
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_DIFF;
                end
            end
            S_DIFF: begin
                if (!i_sts.areal) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.calc_dist = 1'b1;
                    n_state         = S_MX;
                end
            end
            S_ACC: begin
                o_cmd.d2_acc = 1'b1;
                n_state      = r_pass ? S_U : S_MIN;
            end
            S_MIN: begin
                o_cmd.dmin_upd = 1'b1;
                n_j            = r_j + 1'b1;
                n_state        = S_RD;
            end
            S_U: begin
                o_cmd.calc_u = 1'b1;
                n_state      = S_DV1;
            end
            S_DV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_ONE;
                n_state         = S_DV1W;
            end
            S_DV1W: begin
                if (!i_sts.dv_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_V;
                    n_state         = S_DV2W;
                end
            end
            S_DV2W: begin
                if (!i_sts.dv_busy) n_state = S_WLD;
            end
            S_WLD: begin
                o_cmd.w_load = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_WHI;
                n_state       = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_WLO;
                o_cmd.p_load  = 1'b1;
                n_state       = S_PADD;
            end
            S_PADD: begin
                o_cmd.p_add = 1'b1;
                n_state     = S_NUM;
            end
            S_NUM: begin
                o_cmd.num_add = 1'b1;
                n_j           = r_j + 1'b1;
                n_state       = S_RD;
            end
            S_FCHK: begin
                if (i_sts.den_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_NODEN;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_MEAN;
                    n_state         = S_FDW;
                end
            end
            S_FDW: begin
                if (!i_sts.dv_busy) n_state = S_FQ;
            end
            S_FQ: begin
                if (i_sts.q_over) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_SAT;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.sq_start = 1'b1;
                    n_state        = S_SQW;
                end
            end
            S_SQW: begin
                if (i_sts.sq_done) n_state = S_FCMP;
            end
            S_FCMP: begin
                if (i_sts.root_le_cut) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_ZERO;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_E;
                    n_state       = S_FE;
                end
            end
            S_FE: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = RES_PROD;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
